FILE: rtl/core/pdm_pkg.sv
// pdm_pkg: shared types, constants and saturation helpers for the pressure decay monitor
// no dependencies
package pdm_pkg;

  localparam int NumW  = 41;
  localparam int DenW  = 35;
  localparam int CfgW  = 18;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgAdcRef  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSensMin = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSensAtm = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinPa   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDeadbnd = 3'd4;

  typedef logic signed [18:0] pa_out_t;
  typedef logic signed [23:0] rate_t;

  function automatic rate_t sat24(input logic signed [NumW:0] v);
    if (v > 42'sd8388607) return 24'sh7fffff;
    if (v < -42'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [NumW:0] v);
    if (v > 42'sd131071) return 18'sh1ffff;
    if (v < -42'sd131072) return 18'sh20000;
    return v[17:0];
  endfunction

endpackage

FILE: rtl/core/pdm_if.sv
// pdm_in_if and pdm_out_if: valid/ready channels of the pressure decay monitor
// depends on pdm_pkg
interface pdm_in_if #(parameter int SampleW = 12);
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;
  logic [31:0]        time_ms;
  modport source(output valid, adc_sample, time_ms, input ready);
  modport sink(input valid, adc_sample, time_ms, output ready);
endinterface

interface pdm_out_if;
  logic             valid;
  logic             ready;
  pdm_pkg::pa_out_t pressure_pa;
  pdm_pkg::rate_t   drop_rate;
  pdm_pkg::rate_t   rise_speed;
  modport source(output valid, pressure_pa, drop_rate, rise_speed, input ready);
  modport sink(input valid, pressure_pa, drop_rate, rise_speed, output ready);
endinterface

FILE: rtl/core/pressure_decay_monitor.sv
// pressure_decay_monitor: burst mean, pressure map, moving average and decay rates
// depends on pdm_pkg and pdm_if
// a sample that does not end a burst leaves the input ready for the next sample
// a burst-ending sample keeps the input busy until the burst has been processed:
// up to four divisions on one shared restoring divider (skipped when a divisor is
// zero), up to five products on one shared multiplier, shift-add steps for the mV
// scaling, a read and an add per window entry and control steps; a full output adds wait
// reset: asynchronous active low, configuration to defaults, history cleared
module pressure_decay_monitor #(
  parameter int BURST_LEN = 20,
  parameter int WINDOW    = 5,
  parameter int ADC_BITS  = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdm_pkg::CfgW-1:0]    cfg_data_i,
  pdm_in_if.sink                      in_ch,
  pdm_out_if.source                   out_ch
);
  import pdm_pkg::*;

  localparam int SumW  = ADC_BITS + 5;
  localparam int CntW  = $clog2(BURST_LEN + 1);
  localparam int FillW = $clog2(WINDOW + 1);
  localparam int IdxW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AdcMax = (1 << ADC_BITS) - 1;
  localparam int RecK  = SumW + $clog2(BURST_LEN);
  localparam longint RecM = ((64'sd1 <<< RecK) + BURST_LEN - 1) / BURST_LEN;

  typedef enum logic [4:0] {
    S_IDLE, S_MEAN, S_QM, S_DIV, S_M1, S_D1, S_MV, S_M2, S_D2, S_PA, S_RD, S_ACC, S_AVG,
    S_UPD, S_M3, S_D3, S_DEC, S_M4, S_D4, S_SPD, S_OUT
  } state_e;

  state_e st_q, ret_q, dret;

  logic [12:0] ref_q, smin_q, atm_q;
  logic signed [17:0] minp_q;
  logic [15:0] db_q;

  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0] bstart_q, tlast_q, ltime_q, start_q;
  logic primed_q;
  logic signed [17:0] store_q [WINDOW];
  logic signed [17:0] rd_q;
  logic [FillW-1:0] fill_q;
  logic [IdxW-1:0] head_q, idx_q;
  logic signed [22:0] last_q, low_q, avg_q;
  logic signed [23:0] loss_q;
  logic [31:0] rise_q;
  logic signed [21:0] acc_q;
  logic signed [52:0] prod_q;
  logic signed [NumW-1:0] res_q;
  rate_t dec_q, spd_q;

  logic [39:0] quo_q;
  logic [33:0] rem_q, den_q;
  logic neg_q;
  logic [5:0] dcnt_q;

  logic out_valid_q;
  pa_out_t out_pa_q;
  rate_t out_dec_q, out_spd_q;

  logic lnch;
  logic signed [NumW-1:0] dnum;
  logic signed [DenW-1:0] dden;
  logic signed [33:0] ma;
  logic signed [21:0] mb;
  logic signed [13:0] span;
  logic [31:0] dt, el;
  logic [34:0] trial;
  logic signed [22:0] avr;

  assign span = $signed({1'b0, atm_q}) - $signed({1'b0, smin_q});
  assign dt = bstart_q - ltime_q;
  assign el = bstart_q - start_q;
  assign trial = {rem_q, quo_q[39]} - {1'b0, den_q};
  assign avr = avg_q + $signed({19'b0, {4{avg_q[22]}}});

  assign in_ch.ready = (st_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.pressure_pa = out_pa_q;
  assign out_ch.drop_rate = out_dec_q;
  assign out_ch.rise_speed = out_spd_q;

  always_comb begin
    lnch = 1'b0;
    dnum = prod_q[NumW-1:0];
    dden = DenW'(1);
    dret = S_IDLE;
    ma = '0;
    mb = '0;
    case (st_q)
      S_MEAN: begin
        ma = 34'(RecM); mb = 22'(sum_q);
      end
      S_M1: begin
        ma = res_q[33:0]; mb = $signed({9'b0, ref_q});
      end
      S_M2: begin
        ma = res_q[33:0] - $signed({21'b0, smin_q}); mb = -(22'(minp_q));
      end
      S_D2: begin
        lnch = (span != 14'sd0); dden = DenW'(span); dret = S_PA;
      end
      S_AVG: begin
        lnch = 1'b1; dnum = NumW'(acc_q) <<< 4; dden = $signed({{(DenW-FillW){1'b0}}, fill_q});
        dret = S_UPD;
      end
      S_M3: begin
        ma = 34'(loss_q); mb = 22'sd125;
      end
      S_D3: begin
        lnch = (dt != 32'd0); dden = $signed({2'b0, dt, 1'b0}); dret = S_DEC;
      end
      S_M4: begin
        ma = $signed({2'b0, rise_q}); mb = 22'sd125;
      end
      S_D4: begin
        lnch = (el != 32'd0); dden = $signed({2'b0, el, 1'b0}); dret = S_SPD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [22:0] avgv;
    logic signed [23:0] lossv;
    logic [32:0] rsum;
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ret_q <= S_IDLE;
      ref_q <= 13'd3300;
      smin_q <= 13'd500;
      atm_q <= 13'd4460;
      minp_q <= -18'sd98070;
      db_q <= 16'd80;
      sum_q <= '0;
      cnt_q <= '0;
      bstart_q <= '0;
      tlast_q <= '0;
      ltime_q <= '0;
      start_q <= '0;
      primed_q <= 1'b0;
      fill_q <= '0;
      head_q <= '0;
      idx_q <= '0;
      last_q <= '0;
      low_q <= '0;
      rise_q <= '0;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgAdcRef:  ref_q <= cfg_data_i[12:0];
          CfgSensMin: smin_q <= cfg_data_i[12:0];
          CfgSensAtm: atm_q <= cfg_data_i[12:0];
          CfgMinPa:   minp_q <= $signed(cfg_data_i);
          CfgDeadbnd: db_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
      if (lnch) begin
        neg_q <= dnum[NumW-1] ^ dden[DenW-1];
        quo_q <= dnum[NumW-1] ? 40'(-dnum) : dnum[39:0];
        den_q <= dden[DenW-1] ? 34'(-dden) : dden[33:0];
        rem_q <= '0;
        dcnt_q <= 6'd40;
        ret_q <= dret;
        st_q <= S_DIV;
      end else begin
        case (st_q)
          S_IDLE: begin
            if (in_ch.valid) begin
              if (cnt_q == '0) begin
                bstart_q <= in_ch.time_ms;
                sum_q <= SumW'(in_ch.adc_sample);
              end else begin
                sum_q <= sum_q + SumW'(in_ch.adc_sample);
              end
              if (cnt_q == CntW'(BURST_LEN - 1)) begin
                cnt_q <= '0;
                tlast_q <= in_ch.time_ms;
                st_q <= S_MEAN;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
          end
          S_MEAN: begin
            prod_q <= ma * mb;
            st_q <= S_QM;
          end
          S_QM: begin
            res_q <= NumW'(prod_q >>> RecK);
            st_q <= S_M1;
          end
          S_DIV: begin
            if (dcnt_q == '0) begin
              res_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
              st_q <= ret_q;
            end else begin
              if (!trial[34]) rem_q <= trial[33:0];
              else rem_q <= {rem_q[32:0], quo_q[39]};
              quo_q <= {quo_q[38:0], ~trial[34]};
              dcnt_q <= dcnt_q - 1'b1;
            end
          end
          S_M1: begin
            prod_q <= ma * mb;
            st_q <= S_D1;
          end
          S_D1: begin
            rem_q <= prod_q[33:0];
            res_q <= '0;
            st_q <= S_MV;
          end
          S_MV: begin
            if ((rem_q >> ADC_BITS) != '0) begin
              res_q <= res_q + NumW'(rem_q >> ADC_BITS);
              rem_q <= (rem_q & 34'(AdcMax)) + (rem_q >> ADC_BITS);
            end else begin
              if (rem_q == 34'(AdcMax)) res_q <= res_q + 1'b1;
              st_q <= S_M2;
            end
          end
          S_M2: begin
            prod_q <= ma * mb;
            st_q <= S_D2;
          end
          S_D2: begin
            res_q <= '0;
            st_q <= S_PA;
          end
          S_PA: begin
            store_q[head_q] <= sat18((NumW+1)'(minp_q) + (NumW+1)'(res_q));
            head_q <= (head_q == IdxW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
            if (fill_q != FillW'(WINDOW)) fill_q <= fill_q + 1'b1;
            acc_q <= '0;
            idx_q <= '0;
            st_q <= S_RD;
          end
          S_RD: begin
            rd_q <= store_q[idx_q];
            st_q <= S_ACC;
          end
          S_ACC: begin
            acc_q <= acc_q + 22'(rd_q);
            if (FillW'(idx_q) + 1'b1 == fill_q) begin
              st_q <= S_AVG;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q <= S_RD;
            end
          end
          S_UPD: begin
            avgv = res_q[22:0];
            avg_q <= avgv;
            if (!primed_q) begin
              primed_q <= 1'b1;
              last_q <= avgv;
              ltime_q <= bstart_q;
              st_q <= S_IDLE;
            end else begin
              if (avgv < low_q) begin
                low_q <= avgv;
                start_q <= bstart_q;
              end
              lossv = 24'(avgv) - 24'(last_q);
              if (lossv < 0 && (-lossv) < $signed({4'b0, db_q, 4'b0})) lossv = '0;
              loss_q <= lossv;
              if (lossv >= 0) begin
                rsum = {1'b0, rise_q} + 33'(lossv[22:0]);
                rise_q <= rsum[32] ? 32'hffffffff : rsum[31:0];
              end else begin
                rise_q <= '0;
                low_q <= '0;
                start_q <= tlast_q;
              end
              st_q <= S_M3;
            end
          end
          S_M3: begin
            prod_q <= ma * mb;
            st_q <= S_D3;
          end
          S_D3: begin
            res_q <= '0;
            st_q <= S_DEC;
          end
          S_DEC: begin
            dec_q <= sat24((NumW+1)'(res_q));
            st_q <= S_M4;
          end
          S_M4: begin
            prod_q <= ma * mb;
            st_q <= S_D4;
          end
          S_D4: begin
            res_q <= '0;
            st_q <= S_SPD;
          end
          S_SPD: begin
            spd_q <= sat24((NumW+1)'(res_q));
            st_q <= S_OUT;
          end
          S_OUT: begin
            if (!out_valid_q || out_ch.ready) begin
              out_valid_q <= 1'b1;
              out_pa_q <= avr[22:4];
              out_dec_q <= dec_q;
              out_spd_q <= spd_q;
              last_q <= avg_q;
              ltime_q <= bstart_q;
              st_q <= S_IDLE;
            end
          end
          default: st_q <= S_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for pressure_decay_monitor
// drives sample bursts and register writes, predicts each burst result in a scoreboard
// depends on pdm_pkg, pdm_if and the pressure_decay_monitor rtl
module tb_top;
  import pdm_pkg::*;

  localparam int BurstLen  = 20;
  localparam int WinDepth  = 5;
  localparam int AdcMax    = 4095;
  localparam int WdogLimit = 20000;
  localparam int DrainWait = 400;
  localparam int HoldCycles = 3000;

  typedef enum int {IdleNone, IdleSrc, IdleSnk, IdleBoth} idle_mode_e;

  typedef struct {
    pa_out_t pressure;
    rate_t   decay;
    rate_t   speed;
  } burst_result_t;

  class decay_scoreboard;
    int unsigned adc_ref, sens_min, sens_atm, deadband;
    int          min_pa;
    int unsigned acc_sum, acc_cnt;
    bit [31:0]   burst_t0;
    bit          primed;
    int          win[WinDepth];
    int unsigned win_fill, win_head;
    longint      prev_avg, low_avg;
    bit [31:0]   prev_t, timing_t0;
    longint      rise_acc;
    burst_result_t pending[$];
    int          mismatches;

    function new();
      adc_ref = 3300; sens_min = 500; sens_atm = 4460; min_pa = -98070; deadband = 80;
      acc_sum = 0; acc_cnt = 0; burst_t0 = 0; primed = 0;
      win_fill = 0; win_head = 0; prev_avg = 0; low_avg = 0;
      prev_t = 0; timing_t0 = 0; rise_acc = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CfgAdcRef:  adc_ref  = val[12:0];
        CfgSensMin: sens_min = val[12:0];
        CfgSensAtm: sens_atm = val[12:0];
        CfgMinPa:   min_pa   = $signed(val[17:0]);
        CfgDeadbnd: deadband = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint rate_of(longint x, bit [31:0] ms);
      longint den;
      den = ms;
      if (ms == 0) return 0;
      return clip((x * 125) / (den * 2), -8388608, 8388607);
    endfunction

    function void note_sample(bit [11:0] smp, bit [31:0] t);
      longint mean, mv, span, pa, wsum, avg, loss;
      burst_result_t r;
      if (acc_cnt == 0) begin
        burst_t0 = t;
        acc_sum = 0;
      end
      acc_sum += smp;
      acc_cnt++;
      if (acc_cnt < BurstLen) return;
      acc_cnt = 0;
      mean = acc_sum / BurstLen;
      mv = (mean * adc_ref) / AdcMax;
      span = longint'(sens_atm) - longint'(sens_min);
      pa = min_pa;
      if (span != 0) pa += ((mv - longint'(sens_min)) * (-longint'(min_pa))) / span;
      pa = clip(pa, -131072, 131071);
      win[win_head] = int'(pa);
      win_head = (win_head + 1) % WinDepth;
      if (win_fill < WinDepth) win_fill++;
      wsum = 0;
      for (int i = 0; i < win_fill; i++) wsum += win[i];
      avg = (wsum * 16) / longint'(win_fill);
      if (!primed) begin
        primed = 1;
        prev_avg = avg;
        prev_t = burst_t0;
        return;
      end
      if (avg < low_avg) begin
        low_avg = avg;
        timing_t0 = burst_t0;
      end
      loss = avg - prev_avg;
      if (loss < 0 && -loss < longint'(deadband) * 16) loss = 0;
      if (loss >= 0) begin
        rise_acc = clip(rise_acc + loss, 0, 64'hFFFF_FFFF);
      end else begin
        rise_acc = 0;
        low_avg = 0;
        timing_t0 = t;
      end
      r.pressure = pa_out_t'(avg / 16);
      r.decay    = rate_t'(rate_of(loss, burst_t0 - prev_t));
      r.speed    = rate_t'(rate_of(rise_acc, burst_t0 - timing_t0));
      pending = {pending, r};
      prev_avg = avg;
      prev_t = burst_t0;
    endfunction

    function void check_result(pa_out_t p, rate_t d, rate_t s);
      burst_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result p=%0d d=%0d s=%0d", p, d, s);
        return;
      end
      e = pending.pop_front();
      if (e.pressure !== p || e.decay !== d || e.speed !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected p=%0d d=%0d s=%0d, actual p=%0d d=%0d s=%0d",
                   e.pressure, e.decay, e.speed, p, d, s);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  pdm_in_if  in_ch();
  pdm_out_if out_ch();

  pressure_decay_monitor DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  decay_scoreboard sb = new();
  idle_mode_e idle_mode = IdleNone;
  bit hold_req = 0;
  bit hold_done = 0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  // receiver side
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      for (int i = 0; i < HoldCycles; i++) @(negedge clk_i);
      hold_done = 1;
    end else if (idle_mode == IdleSnk) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 73);
    end else if (idle_mode == IdleBoth) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.pressure_pa, out_ch.drop_rate, out_ch.rise_speed);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WdogLimit) begin
      $display("** pressure_decay_monitor: FAILED **");
      $finish;
    end
  end

  function automatic bit src_idle();
    case (idle_mode)
      IdleSrc:  return $urandom_range(0, 99) < 73;
      IdleBoth: return $urandom_range(0, 99) < 8;
      default:  return 0;
    endcase
  endfunction

  task automatic send_sample(int a, bit [31:0] t);
    @(negedge clk_i);
    while (src_idle()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= a[11:0];
    in_ch.time_ms <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(a[11:0], t);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(int ar, int smin, int satm, int mp, int db);
    write_reg(CfgAdcRef, ar);
    write_reg(CfgSensMin, smin);
    write_reg(CfgSensAtm, satm);
    write_reg(CfgMinPa, mp);
    write_reg(CfgDeadbnd, db);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one burst around a sample level; bursts with a negative noise ignore the level
  task automatic send_burst(int level, int noise, bit [31:0] t0, int step);
    int a;
    for (int i = 0; i < BurstLen; i++) begin
      if (noise < 0) a = $urandom_range(0, AdcMax);
      else a = level + $urandom_range(0, 2 * noise) - noise;
      if (a < 0) a = 0;
      if (a > AdcMax) a = AdcMax;
      send_sample(a, t0 + i * step);
    end
  endtask

  initial begin
    bit [31:0] tcur;
    int level, step, noise, pick;
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    in_ch.time_ms = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes: full scale, then zero with the same timestamps, then a wrapping clock
    send_burst(AdcMax, 0, 32'hFFFF_FFF0, 0);
    send_burst(0, 0, 32'hFFFF_FFF0, 0);
    send_burst(AdcMax, 0, 32'hFFFF_FFF8, 1);

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      case (ph)
        1: write_all(5000, 0, 5000, -131072, 0);
        2: write_all(1, 5000, 0, 0, 65535);
        3: write_all(3300, 2000, 2000, -98070, 80);
        9: write_all(3300, 500, 4460, -98070, 80);
        default: write_all($urandom_range(1, 5000), $urandom_range(0, 5000),
                           $urandom_range(0, 5000), -$urandom_range(0, 131072),
                           $urandom_range(0, 400));
      endcase
      idle_mode = idle_mode_e'(ph % 4);
      tcur = $urandom;
      level = $urandom_range(0, AdcMax);
      if (ph == 5) hold_req = 1;
      for (int b = 0; b < 4; b++) begin
        pick = $urandom_range(0, 9);
        step = (pick == 0) ? 0 : $urandom_range(1, 60);
        noise = (pick == 1) ? -1 : $urandom_range(0, 3);
        if (pick == 2) level = $urandom_range(0, AdcMax);
        else level += $urandom_range(0, 24) - 12;
        if (level < 0) level = 0;
        if (level > AdcMax) level = AdcMax;
        send_burst(level, noise, tcur, step);
        tcur += BurstLen * step + ((pick == 0) ? 0 : $urandom_range(0, 2000));
        if (ph == 7 && b == 2) wait_drained();
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** pressure_decay_monitor: PASSED **");
    end else begin
      $display("** pressure_decay_monitor: FAILED **");
    end
    $finish;
  end
endmodule
